// ===== hdl/nrfr_pkg.sv =====
// Shared types and constants for the nonce response frame receiver.
// No dependencies; imported by every module in hdl/.
`timescale 1ns / 1ps

package nrfr_pkg;

  localparam int FRAME_LENGTH = 11;
  localparam int CNT_W        = 4;

  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'h55;
  localparam logic [7:0] CHIP_COUNT_RST = 8'd88;

  typedef logic [7:0]       byte_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    ST_NEED_MORE = 2'd0,
    ST_DECODED   = 2'd1,
    ST_NOT_NONCE = 2'd2,
    ST_BAD_CHIP  = 2'd3
  } status_t;

  // Decoded fields of a complete frame
  typedef struct packed {
    logic [31:0] nonce_wire;
    logic [31:0] nonce_swapped;
    logic [23:0] version_raw;
    logic [31:0] version_host;
    logic [4:0]  slot_number;
    logic [6:0]  chip_number;
    logic [6:0]  core_number;
    logic [7:0]  payload_byte;
    logic [4:0]  tail_bits;
  } fields_t;

  // Verdict on a word plus the fill level to carry on with after a full frame
  typedef struct packed {
    status_t status;
    count_t  cnt_nxt;
  } dec_t;

endpackage

// ===== hdl/nonce_response_frame_receiver.sv =====
// Top level: sync hunt, byte count, shift chain of cells and output register.
// Depends on nrfr_pkg, nrfr_cell and nrfr_decode.
// The result for a byte is registered on accept and is on the out_ port the cycle after.
// Throughput: one byte per cycle while out_ready is high; a held result blocks in_ready.
// The 11th frame byte is decoded straight off the 10-byte cell chain plus the incoming byte.
// Reset (rst_n low, synchronous): hunting with no bytes held, no result pending,
// chip_count back to 88. Cell contents are not reset.
`timescale 1ns / 1ps

module nonce_response_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_nonce_wire,
  output logic [31:0] out_nonce_swapped,
  output logic [23:0] out_version_raw,
  output logic [31:0] out_version_host,
  output logic [4:0]  out_slot_number,
  output logic [6:0]  out_chip_number,
  output logic [6:0]  out_core_number,
  output logic [7:0]  out_payload_byte,
  output logic [4:0]  out_tail_bits,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import nrfr_pkg::*;

  localparam int NCELL = FRAME_LENGTH - 1;

  logic       accept;
  count_t     cnt_r, cnt_nxt;
  logic [7:0] chip_count_r;
  logic       out_valid_r;
  status_t    status_r;
  fields_t    fld_r;

  byte_t              cell_q   [NCELL];
  byte_t              frame    [FRAME_LENGTH];
  logic [NCELL-1:0]   sync_hit;
  dec_t               dec;
  fields_t            fld;

  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  // shift chain: newest held byte sits in the last cell
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    byte_t d_in;
    if (j == NCELL - 1) begin : g_tail
      assign d_in = in_rx_byte;
    end else begin : g_body
      assign d_in = cell_q[j+1];
    end
    nrfr_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .d_in     (d_in),
      .q        (cell_q[j]),
      .sync_hit (sync_hit[j])
    );
    assign frame[j] = cell_q[j];
  end
  assign frame[FRAME_LENGTH-1] = in_rx_byte;

  nrfr_decode u_decode (
    .frame      (frame),
    .sync_hit   (sync_hit),
    .chip_count (chip_count_r),
    .complete   (cnt_r == count_t'(FRAME_LENGTH - 1)),
    .dec        (dec),
    .fld        (fld)
  );

  // fill level of the frame
  always_comb begin
    priority if (cnt_r == '0) begin
      cnt_nxt = (in_rx_byte == SYNC_A) ? count_t'(1) : '0;
    end else if (cnt_r == count_t'(1)) begin
      priority if (in_rx_byte == SYNC_B) cnt_nxt = count_t'(2);
      else if (in_rx_byte == SYNC_A)     cnt_nxt = count_t'(1);
      else                               cnt_nxt = '0;
    end else if (cnt_r >= count_t'(FRAME_LENGTH)) begin
      cnt_nxt = '0;
    end else if (cnt_r == count_t'(FRAME_LENGTH - 1)) begin
      cnt_nxt = dec.cnt_nxt;
    end else begin
      cnt_nxt = cnt_r + count_t'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      chip_count_r <= CHIP_COUNT_RST;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        chip_count_r <= cfg_wdata;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= dec.status;
      fld_r    <= fld;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_nonce_wire    = fld_r.nonce_wire;
  assign out_nonce_swapped = fld_r.nonce_swapped;
  assign out_version_raw   = fld_r.version_raw;
  assign out_version_host  = fld_r.version_host;
  assign out_slot_number   = fld_r.slot_number;
  assign out_chip_number   = fld_r.chip_number;
  assign out_core_number   = fld_r.core_number;
  assign out_payload_byte  = fld_r.payload_byte;
  assign out_tail_bits     = fld_r.tail_bits;

`ifndef NO_ASSERTIONS
  // fill level never reaches a full frame between words
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < count_t'(FRAME_LENGTH))
    else $error("byte count out of range");

  // a non-sync byte while hunting leaves the receiver hunting
  a_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cnt_r == '0 && in_rx_byte != SYNC_A |=> cnt_r == '0)
    else $error("hunt left without sync byte");

  // the word completing a frame always carries a verdict
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cnt_r == count_t'(FRAME_LENGTH - 1) |=> status_r != ST_NEED_MORE)
    else $error("complete frame gave need-more");

  // a decoded frame has a chip index below the configured count
  a_chip_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_DECODED |-> {1'b0, fld_r.chip_number} < chip_count_r)
    else $error("decoded chip index out of range");

  // anything but a decoded frame carries zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_DECODED |-> fld_r == '0)
    else $error("non-decoded word has fields set");
`endif

endmodule

// ===== hdl/nrfr_cell.sv =====
// One byte cell of the receive shift chain; flags a 0xAA 0x55 pair at its slot.
// Depends on nrfr_pkg.
`timescale 1ns / 1ps

module nrfr_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  nrfr_pkg::byte_t d_in,
  output nrfr_pkg::byte_t q,
  output logic          sync_hit
);
  import nrfr_pkg::*;

  byte_t byte_r;

  // shift in the neighbour's byte (the incoming byte for the last cell) on every accepted word
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= d_in;
    end
  end

  assign q = byte_r;

  // sync pair starts here when this byte is 0xAA and the next one is 0x55
  assign sync_hit = (byte_r == SYNC_A) && (d_in == SYNC_B);

endmodule

// ===== hdl/nrfr_decode.sv =====
// Field decode, chip check and resync fill level for a complete frame.
// Depends on nrfr_pkg; purely combinational.
`timescale 1ns / 1ps

module nrfr_decode (
  input  nrfr_pkg::byte_t              frame [nrfr_pkg::FRAME_LENGTH],
  input  logic [nrfr_pkg::FRAME_LENGTH-2:0] sync_hit,
  input  logic [7:0]                   chip_count,
  input  logic                         complete,
  output nrfr_pkg::dec_t               dec,
  output nrfr_pkg::fields_t            fld
);
  import nrfr_pkg::*;

  byte_t       last_b;
  logic [31:0] nonce;
  logic [6:0]  chip;
  logic [23:0] vraw;
  count_t      keep;

  always_comb begin
    last_b = frame[FRAME_LENGTH-1];
    nonce  = {frame[2], frame[3], frame[4], frame[5]};
    chip   = nonce[24:18];
    // version bits are spread over bytes 8 and 9
    vraw   = {frame[9][2:0], 5'd0, frame[8][2:0], frame[9][7:3], 3'd0, frame[8][7:3]};

    // resync: lowest inner sync pair wins, else a trailing 0xAA, else empty
    keep = (last_b == SYNC_A) ? count_t'(1) : '0;
    for (int p = FRAME_LENGTH - 2; p >= 1; p--) begin
      if (sync_hit[p]) begin
        keep = count_t'(FRAME_LENGTH - p);
      end
    end

    dec.status  = ST_NEED_MORE;
    dec.cnt_nxt = '0;
    fld         = '0;
    if (complete) begin
      priority if (!last_b[7]) begin
        dec.status = ST_NOT_NONCE;
      end else if ({1'b0, chip} >= chip_count) begin
        dec.status  = ST_BAD_CHIP;
        dec.cnt_nxt = keep;
      end else begin
        dec.status        = ST_DECODED;
        fld.nonce_wire    = nonce;
        fld.nonce_swapped = {frame[5], frame[4], frame[3], frame[2]};
        fld.version_raw   = vraw;
        fld.version_host  = {vraw[7:0], vraw[15:8], vraw[23:16], 8'd0};
        fld.slot_number   = frame[7][7:3];
        fld.chip_number   = chip;
        fld.core_number   = nonce[31:25];
        fld.payload_byte  = frame[6];
        fld.tail_bits     = last_b[4:0];
      end
    end
  end

endmodule
